### sv/qcc_pkg.sv
`timescale 1ns / 1ps

package qcc_pkg;

  // Event codes carried in the op field of a request.
  typedef enum logic [2:0] {
    OP_SENT    = 3'd0,
    OP_ACKED   = 3'd1,
    OP_LOST    = 3'd2,
    OP_ECN     = 3'd3,
    OP_PERSIST = 3'd4,
    OP_QUERY   = 3'd5,
    OP_RESET   = 3'd6
  } qcc_op_t;

  typedef enum logic [1:0] {
    PH_SLOW_START = 2'd0,
    PH_AVOID      = 2'd1,
    PH_RECOVERY   = 2'd2
  } qcc_phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_GROW,
    S_CONG,
    S_FIN
  } qcc_state_t;

  // Configuration register indexes.
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DATAGRAM_SIZE  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INITIAL_WINDOW = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_WINDOW     = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOSS_REDUCTION = 2'd3;

  localparam int DS_RESET    = 1200;
  localparam int IWP_RESET   = 10;
  localparam int MWP_RESET   = 2;
  localparam int LOSSQ_RESET = 128;
  localparam int RESET_WINDOW = DS_RESET * IWP_RESET;

  localparam int BYTES_BITS = 16;
  localparam int DS_BITS    = 16;
  localparam int PKTS_BITS  = 8;
  localparam int LOSSQ_BITS = 9;
  localparam int OUT_BITS   = 32;

  // Growth dividend: datagram size times acked bytes.
  localparam int PROD_BITS = DS_BITS + BYTES_BITS;
  localparam int CNT_BITS  = $clog2(PROD_BITS);

endpackage

### sv/qcc_if.sv
`timescale 1ns / 1ps

interface qcc_in_if #(
  parameter int TIME_BITS = 48
);
  import qcc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [2:0]            op;
  logic [BYTES_BITS-1:0] byte_count;
  logic                  counts_in_flight;
  logic [TIME_BITS-1:0]  send_stamp;
  logic [TIME_BITS-1:0]  now_time;

  modport source (
    output valid, op, byte_count, counts_in_flight, send_stamp, now_time,
    input  ready
  );
  modport sink (
    input  valid, op, byte_count, counts_in_flight, send_stamp, now_time,
    output ready
  );
endinterface

interface qcc_out_if;
  import qcc_pkg::*;

  logic                valid;
  logic                ready;
  logic [OUT_BITS-1:0] window;
  logic [OUT_BITS-1:0] threshold;
  logic [OUT_BITS-1:0] in_flight_bytes;
  logic [1:0]          phase;
  logic [OUT_BITS-1:0] room;
  logic                send_ok;

  modport source (
    output valid, window, threshold, in_flight_bytes, phase, room, send_ok,
    input  ready
  );
  modport sink (
    input  valid, window, threshold, in_flight_bytes, phase, room, send_ok,
    output ready
  );
endinterface

interface qcc_cfg_if;
  import qcc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### sv/quic_congestion_window_controller.sv
`timescale 1ns / 1ps
// NewReno congestion window controller for one QUIC connection.
// in_req carries one event request (sent, acked, lost, ECN mark, persistent
// congestion, query, reset) with its byte count, in-flight flag and the send
// and current timestamps. out_rsp returns exactly one response per request:
// window, threshold, bytes in flight, phase, room and the can-send answer,
// all taken after the event. cfg_req writes the four settings by index; it
// is always ready and must only be used while no request is in progress.
// Most events pass through a prepare step and a final step; a loss or mark
// that opens recovery adds a congestion step, and an ack in congestion
// avoidance adds the divide and grow steps. The ack growth term is found by
// a restoring divider that runs one quotient bit per cycle on a single
// shared subtractor, 32 steps. One request is in progress at a time; in_req
// is ready only in idle, so the next request is accepted only after the
// current one has left its final step and returned to idle.
// The response sits in an output register, so a new request is accepted
// while the previous response still waits; if the receiver stalls, the
// next response holds in its final step until the register frees up.
// Reset (rst_n low, synchronous) restores the settings to their defaults
// and the window to 12000 bytes, threshold all ones, nothing in flight,
// slow start, recovery start zero, and clears out_rsp.valid.
module quic_congestion_window_controller #(
  parameter int TIME_BITS   = 48,
  parameter int WINDOW_BITS = 32
) (
  input  logic    clk,
  input  logic    rst_n,
  qcc_in_if.sink  in_req,
  qcc_out_if.source out_rsp,
  qcc_cfg_if.sink cfg_req
);
  import qcc_pkg::*;

  localparam int W  = WINDOW_BITS;
  localparam int XW = (W > PROD_BITS) ? W : PROD_BITS;
  localparam logic [W-1:0]  WMAX   = {W{1'b1}};
  localparam logic [XW-1:0] WMAX_X = XW'(WMAX);

  // Add with saturation at the window's full scale.
  function automatic logic [W-1:0] sat_add(input logic [XW-1:0] a,
                                           input logic [XW-1:0] b);
    logic [XW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum > {1'b0, WMAX_X}) return WMAX;
    return W'(sum);
  endfunction

  function automatic logic [W-1:0] sat_clip(input logic [XW-1:0] a);
    if (a > WMAX_X) return WMAX;
    return W'(a);
  endfunction

  // Settings.
  logic [DS_BITS-1:0]    ds_r, ds_nxt;
  logic [PKTS_BITS-1:0]  iwp_r, iwp_nxt;
  logic [PKTS_BITS-1:0]  mwp_r, mwp_nxt;
  logic [LOSSQ_BITS-1:0] lossq_r, lossq_nxt;

  // Connection state.
  logic [W-1:0]         cwnd_r, cwnd_nxt;
  logic [W-1:0]         ssth_r, ssth_nxt;
  logic [W-1:0]         flight_r, flight_nxt;
  qcc_phase_t           phase_r, phase_nxt;
  logic [TIME_BITS-1:0] rstart_r, rstart_nxt;

  // Sequencer and the request being worked.
  qcc_state_t           state_r, state_nxt;
  logic [2:0]           op_r, op_nxt;
  logic [BYTES_BITS-1:0] bytes_r, bytes_nxt;
  logic                 counted_r, counted_nxt;
  logic [TIME_BITS-1:0] sent_r, sent_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;

  // Shared divider and congestion scratch.
  logic [PROD_BITS-1:0]  divd_r, divd_nxt;
  logic [W-1:0]          rem_r, rem_nxt;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic [W:0]            prod_r, prod_nxt;
  logic [LOSSQ_BITS-1:0] lo_r, lo_nxt;
  logic [W-1:0]          minw_r, minw_nxt;

  // Response register.
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_BITS-1:0] out_window_r, out_window_nxt;
  logic [OUT_BITS-1:0] out_thresh_r, out_thresh_nxt;
  logic [OUT_BITS-1:0] out_flight_r, out_flight_nxt;
  logic [1:0]          out_phase_r, out_phase_nxt;
  logic [OUT_BITS-1:0] out_room_r, out_room_nxt;
  logic                out_ok_r, out_ok_nxt;

  assign in_req.ready  = (state_r == S_IDLE);
  assign cfg_req.ready = 1'b1;

  assign out_rsp.valid           = out_valid_r;
  assign out_rsp.window          = out_window_r;
  assign out_rsp.threshold       = out_thresh_r;
  assign out_rsp.in_flight_bytes = out_flight_r;
  assign out_rsp.phase           = out_phase_r;
  assign out_rsp.room            = out_room_r;
  assign out_rsp.send_ok         = out_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ds_r        <= DS_BITS'(DS_RESET);
      iwp_r       <= PKTS_BITS'(IWP_RESET);
      mwp_r       <= PKTS_BITS'(MWP_RESET);
      lossq_r     <= LOSSQ_BITS'(LOSSQ_RESET);
      cwnd_r      <= W'(RESET_WINDOW);
      ssth_r      <= WMAX;
      flight_r    <= '0;
      phase_r     <= PH_SLOW_START;
      rstart_r    <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      ds_r        <= ds_nxt;
      iwp_r       <= iwp_nxt;
      mwp_r       <= mwp_nxt;
      lossq_r     <= lossq_nxt;
      cwnd_r      <= cwnd_nxt;
      ssth_r      <= ssth_nxt;
      flight_r    <= flight_nxt;
      phase_r     <= phase_nxt;
      rstart_r    <= rstart_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    bytes_r      <= bytes_nxt;
    counted_r    <= counted_nxt;
    sent_r       <= sent_nxt;
    now_r        <= now_nxt;
    divd_r       <= divd_nxt;
    rem_r        <= rem_nxt;
    prod_r       <= prod_nxt;
    lo_r         <= lo_nxt;
    minw_r       <= minw_nxt;
    out_window_r <= out_window_nxt;
    out_thresh_r <= out_thresh_nxt;
    out_flight_r <= out_flight_nxt;
    out_phase_r  <= out_phase_nxt;
    out_room_r   <= out_room_nxt;
    out_ok_r     <= out_ok_nxt;
  end

  always_comb begin
    logic                  rec;
    logic [W-1:0]          bytes_w;
    logic [W-1:0]          fl_drop;
    logic [W-1:0]          grown;
    logic [W-1:0]          dvsr;
    logic [W:0]            shifted;
    logic                  qbit;
    logic [PROD_BITS-1:0]  inc;
    logic [W-1:0]          th;
    logic [W-1:0]          minw;
    logic [2*LOSSQ_BITS-2:0] lo_prod;

    state_nxt      = state_r;
    ds_nxt         = ds_r;
    iwp_nxt        = iwp_r;
    mwp_nxt        = mwp_r;
    lossq_nxt      = lossq_r;
    cwnd_nxt       = cwnd_r;
    ssth_nxt       = ssth_r;
    flight_nxt     = flight_r;
    phase_nxt      = phase_r;
    rstart_nxt     = rstart_r;
    op_nxt         = op_r;
    bytes_nxt      = bytes_r;
    counted_nxt    = counted_r;
    sent_nxt       = sent_r;
    now_nxt        = now_r;
    divd_nxt       = divd_r;
    rem_nxt        = rem_r;
    cnt_nxt        = cnt_r;
    prod_nxt       = prod_r;
    lo_nxt         = lo_r;
    minw_nxt       = minw_r;
    out_valid_nxt  = out_valid_r;
    out_window_nxt = out_window_r;
    out_thresh_nxt = out_thresh_r;
    out_flight_nxt = out_flight_r;
    out_phase_nxt  = out_phase_r;
    out_room_nxt   = out_room_r;
    out_ok_nxt     = out_ok_r;

    // Recovery holds for packets sent no later than the recovery start.
    rec     = (phase_r == PH_RECOVERY) && (sent_r <= rstart_r);
    bytes_w = W'(bytes_r);
    fl_drop = (counted_r && flight_r >= bytes_w) ? flight_r - bytes_w : flight_r;
    grown   = sat_add(XW'(cwnd_r), XW'(bytes_r));
    dvsr    = (cwnd_r == '0) ? W'(1) : cwnd_r;
    shifted = {rem_r, divd_r[PROD_BITS-1]};
    qbit    = (shifted >= {1'b0, dvsr});
    inc     = (divd_r == '0) ? PROD_BITS'(1) : divd_r;
    minw    = sat_clip(XW'(PROD_BITS'(ds_r) * PROD_BITS'(mwp_r)));
    lo_prod = cwnd_r[7:0] * lossq_r;
    if (prod_r > {1'b0, WMAX}) th = WMAX;
    else th = sat_add(XW'(prod_r[W-1:0]), XW'(lo_r));

    // Response register drains independently of the sequencer.
    if (out_rsp.ready) out_valid_nxt = 1'b0;

    if (cfg_req.valid) begin
      case (cfg_req.index)
        CFG_DATAGRAM_SIZE:  ds_nxt    = cfg_req.data;
        CFG_INITIAL_WINDOW: iwp_nxt   = cfg_req.data[PKTS_BITS-1:0];
        CFG_MIN_WINDOW:     mwp_nxt   = cfg_req.data[PKTS_BITS-1:0];
        CFG_LOSS_REDUCTION: lossq_nxt = cfg_req.data[LOSSQ_BITS-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          op_nxt      = in_req.op;
          bytes_nxt   = in_req.byte_count;
          counted_nxt = in_req.counts_in_flight;
          sent_nxt    = in_req.send_stamp;
          now_nxt     = in_req.now_time;
          state_nxt   = S_PREP;
        end
      end

      S_PREP: begin
        state_nxt = S_FIN;
        case (op_r)
          OP_SENT: flight_nxt = sat_add(XW'(flight_r), XW'(bytes_r));
          OP_ACKED: begin
            flight_nxt = fl_drop;
            if (!rec) begin
              if (phase_r == PH_SLOW_START) begin
                cwnd_nxt  = grown;
                phase_nxt = (grown >= ssth_r) ? PH_AVOID : PH_SLOW_START;
              end else begin
                // Start the growth divide: datagram * bytes / window.
                phase_nxt = PH_AVOID;
                divd_nxt  = PROD_BITS'(sat_clip(XW'(PROD_BITS'(ds_r) *
                                                     PROD_BITS'(bytes_r))));
                rem_nxt   = '0;
                cnt_nxt   = '0;
                state_nxt = S_DIV;
              end
            end
          end
          OP_LOST, OP_ECN: begin
            if (op_r == OP_LOST) flight_nxt = fl_drop;
            if (!rec) begin
              rstart_nxt = now_r;
              phase_nxt  = PH_RECOVERY;
              prod_nxt   = (W+1)'(cwnd_r >> 8) * (W+1)'(lossq_r);
              lo_nxt     = lo_prod[2*LOSSQ_BITS-2:8];
              minw_nxt   = minw;
              state_nxt  = S_CONG;
            end
          end
          OP_PERSIST: begin
            cwnd_nxt   = minw;
            ssth_nxt   = minw;
            phase_nxt  = PH_SLOW_START;
            rstart_nxt = '0;
          end
          OP_RESET: begin
            cwnd_nxt   = sat_clip(XW'(PROD_BITS'(ds_r) * PROD_BITS'(iwp_r)));
            ssth_nxt   = WMAX;
            flight_nxt = '0;
            phase_nxt  = PH_SLOW_START;
            rstart_nxt = '0;
          end
          default: ;
        endcase
      end

      S_DIV: begin
        // One restoring step per cycle, quotient bits shift in at the bottom.
        rem_nxt  = qbit ? W'(shifted - {1'b0, dvsr}) : W'(shifted);
        divd_nxt = {divd_r[PROD_BITS-2:0], qbit};
        cnt_nxt  = cnt_r + CNT_BITS'(1);
        if (cnt_r == CNT_BITS'(PROD_BITS - 1)) state_nxt = S_GROW;
      end

      S_GROW: begin
        cwnd_nxt  = sat_add(XW'(cwnd_r), XW'(inc));
        state_nxt = S_FIN;
      end

      S_CONG: begin
        ssth_nxt  = th;
        cwnd_nxt  = (th > minw_r) ? th : minw_r;
        state_nxt = S_FIN;
      end

      S_FIN: begin
        // Hold here until the response register is free.
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt  = 1'b1;
          out_window_nxt = OUT_BITS'(cwnd_r);
          out_thresh_nxt = OUT_BITS'(ssth_r);
          out_flight_nxt = OUT_BITS'(flight_r);
          out_phase_nxt  = phase_r;
          out_room_nxt   = (flight_r >= cwnd_r) ? '0 : OUT_BITS'(cwnd_r - flight_r);
          if (bytes_r == '0) out_ok_nxt = (flight_r < cwnd_r);
          else out_ok_nxt = (bytes_w <= cwnd_r) && (flight_r <= cwnd_r - bytes_w);
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

### sv/qcc_checker.sv
`timescale 1ns / 1ps

module qcc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_window,
  input logic [31:0] out_in_flight_bytes,
  input logic [31:0] out_room
);

  // Hold a pending response until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("response dropped before it was taken");

  // Work on one request at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in progress");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("response valid right after reset");

  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_room == 32'd0) == (out_in_flight_bytes >= out_window)) &&
                  (out_room == 32'd0 || out_room == out_window - out_in_flight_bytes))
    else $error("room does not match window and bytes in flight");

endmodule

bind quic_congestion_window_controller qcc_checker u_qcc_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_req.valid),
  .in_ready            (in_req.ready),
  .out_valid           (out_rsp.valid),
  .out_ready           (out_rsp.ready),
  .out_window          (out_rsp.window),
  .out_in_flight_bytes (out_rsp.in_flight_bytes),
  .out_room            (out_rsp.room)
);

### tb/sv/quic_congestion_window_controller_tb.sv
`timescale 1ns / 1ps

module quic_congestion_window_controller_tb;
  import qcc_pkg::*;

  localparam int TIME_BITS   = 48;
  localparam int WINDOW_BITS = 32;
  localparam logic [63:0] WIN_MAX = (64'd1 << WINDOW_BITS) - 64'd1;
  localparam logic [TIME_BITS-1:0] STAMP_MAX = '1;
  // No event code 7 in the package; the block must treat it as a no-op.
  localparam logic [2:0] OP_UNUSED = 3'd7;
  // Run limit, set well above what a correct run needs.
  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  // Longest request (ack in congestion avoidance) plus output register slack.
  localparam int TAIL_CYCLES = 60;
  localparam int LONG_HOLD   = 300;

  typedef struct packed {
    logic [2:0]           op;
    logic [15:0]          bytes;
    logic                 counted;
    logic [TIME_BITS-1:0] sent;
    logic [TIME_BITS-1:0] now;
  } cc_event_t;

  typedef struct packed {
    logic [31:0] window;
    logic [31:0] threshold;
    logic [31:0] flight;
    logic [1:0]  phase;
    logic [31:0] room;
    logic        send_ok;
  } window_report_t;

  // An outstanding packet as the traffic generator remembers it.
  typedef struct {
    logic [15:0]          bytes;
    logic [TIME_BITS-1:0] stamp;
  } unacked_pkt_t;

  logic clk;
  logic rst_n;

  qcc_in_if #(.TIME_BITS(TIME_BITS)) in_req();
  qcc_out_if out_rsp();
  qcc_cfg_if cfg_req();

  quic_congestion_window_controller #(
    .TIME_BITS  (TIME_BITS),
    .WINDOW_BITS(WINDOW_BITS)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .out_rsp(out_rsp),
    .cfg_req(cfg_req)
  );

  // ---------------------------------------------------------------------------
  // Window model: settings and connection state, updated in request order.
  // ---------------------------------------------------------------------------
  logic [63:0]          dgram_m;
  logic [63:0]          init_pkts_m;
  logic [63:0]          min_pkts_m;
  logic [63:0]          lossq_m;
  logic [63:0]          win_m;
  logic [63:0]          thresh_m;
  logic [63:0]          flight_m;
  qcc_phase_t           phase_m;
  logic [TIME_BITS-1:0] rec_start_m;

  cc_event_t      req_backlog[$];    // requests waiting for the driver
  window_report_t report_expect[$];  // predicted responses, oldest first
  unacked_pkt_t   unacked[$];

  cc_event_t            offer;
  logic [TIME_BITS-1:0] stamp_now;
  bit                   calm;        // phase with no random gaps on either side
  int                   tx_gap         = 0;
  int                   rx_gap         = 0;
  int                   rx_hold        = 0;
  int                   hold_mark      = 500;
  int                   responses_seen = 0;
  int                   mismatches     = 0;
  int unsigned          cycles         = 0;

  function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b);
    if (a > WIN_MAX || b > WIN_MAX || WIN_MAX - a < b) return WIN_MAX;
    return a + b;
  endfunction

  function automatic logic [63:0] sat_prod(input logic [63:0] a, input logic [63:0] b);
    if (a != 0 && b > WIN_MAX / a) return WIN_MAX;
    return a * b;
  endfunction

  function automatic bit held_in_recovery(input logic [TIME_BITS-1:0] sent);
    return phase_m == PH_RECOVERY && sent <= rec_start_m;
  endfunction

  // Drop acked or lost bytes if counted, unless that would underflow.
  function automatic void retire_flight(input logic [63:0] nbytes, input logic counted);
    if (counted && flight_m >= nbytes) flight_m = flight_m - nbytes;
  endfunction

  function automatic void restart_model();
    win_m       = sat_prod(init_pkts_m, dgram_m);
    thresh_m    = WIN_MAX;
    flight_m    = '0;
    phase_m     = PH_SLOW_START;
    rec_start_m = '0;
  endfunction

  // Loss or ECN mark: at most one cut per recovery period.
  function automatic void cut_window(input logic [TIME_BITS-1:0] sent,
                                     input logic [TIME_BITS-1:0] now);
    logic [63:0] q, hi, lo, th, floor_w;
    q  = lossq_m & 64'h1FF;
    hi = win_m >> 8;
    lo = ((win_m & 64'hFF) * q) >> 8;
    if (held_in_recovery(sent)) return;
    rec_start_m = now;
    phase_m     = PH_RECOVERY;
    if (q != 0 && hi > WIN_MAX / q) begin
      th = WIN_MAX;
    end else begin
      th = hi * q;
      th = (WIN_MAX - th < lo) ? WIN_MAX : th + lo;
    end
    thresh_m = th;
    floor_w  = sat_prod(min_pkts_m, dgram_m);
    win_m    = (th > floor_w) ? th : floor_w;
  endfunction

  function automatic window_report_t predict_event(input cc_event_t r);
    window_report_t rep;
    logic [63:0] nbytes, div, inc;
    nbytes = 64'(r.bytes);
    case (r.op)
      OP_SENT: flight_m = sat_sum(flight_m, nbytes);
      OP_ACKED: begin
        retire_flight(nbytes, r.counted);
        if (!held_in_recovery(r.sent)) begin
          if (phase_m == PH_RECOVERY) phase_m = PH_AVOID;
          if (phase_m == PH_SLOW_START) begin
            win_m = sat_sum(win_m, nbytes);
            if (win_m >= thresh_m) phase_m = PH_AVOID;
          end else begin
            div = (win_m == 0) ? 64'd1 : win_m;
            inc = sat_prod(dgram_m, nbytes) / div;
            if (inc == 0) inc = 64'd1;
            win_m = sat_sum(win_m, inc);
          end
        end
      end
      OP_LOST: begin
        retire_flight(nbytes, r.counted);
        cut_window(r.sent, r.now);
      end
      OP_ECN: cut_window(r.sent, r.now);
      OP_PERSIST: begin
        win_m       = sat_prod(min_pkts_m, dgram_m);
        thresh_m    = win_m;
        phase_m     = PH_SLOW_START;
        rec_start_m = '0;
      end
      OP_RESET: restart_model();
      default: ;
    endcase
    rep.window    = win_m[31:0];
    rep.threshold = thresh_m[31:0];
    rep.flight    = flight_m[31:0];
    rep.phase     = phase_m;
    rep.room      = (flight_m >= win_m) ? 32'd0 : 32'(win_m - flight_m);
    if (r.bytes == 0) rep.send_ok = flight_m < win_m;
    else rep.send_ok = (nbytes <= win_m) && (flight_m <= win_m - nbytes);
    return rep;
  endfunction

  // Gap length: mostly none, sometimes short, rarely long.
  function automatic int pick_gap();
    int r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [TIME_BITS-1:0] rand_stamp();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[TIME_BITS-1:0];
  endfunction

  task automatic push_req(input logic [2:0] op, input logic [15:0] nbytes,
                          input logic counted, input logic [TIME_BITS-1:0] sent,
                          input logic [TIME_BITS-1:0] now);
    cc_event_t e;
    e.op      = op;
    e.bytes   = nbytes;
    e.counted = counted;
    e.sent    = sent;
    e.now     = now;
    req_backlog.push_back(e);
  endtask

  task automatic check_field(input string fname, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("response %0d %s: expected %0d, actual %0d", responses_seen, fname, want, got);
      mismatches++;
    end
  endtask

  // Hold until the driver has nothing left and every response is back.
  task automatic wait_quiet();
    while (req_backlog.size() != 0 || in_req.valid || report_expect.size() != 0)
      @(posedge clk);
  endtask

  // Write one setting while the block is idle and mirror it into the model.
  task automatic write_setting(input logic [CFG_IDX_BITS-1:0] idx,
                               input logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_req.valid <= 1'b1;
    cfg_req.index <= idx;
    cfg_req.data  <= val;
    @(posedge clk);
    while (!cfg_req.ready) @(posedge clk);
    cfg_req.valid <= 1'b0;
    case (idx)
      CFG_DATAGRAM_SIZE:  dgram_m     = 64'(val);
      CFG_INITIAL_WINDOW: init_pkts_m = 64'(val[7:0]);
      CFG_MIN_WINDOW:     min_pkts_m  = 64'(val[7:0]);
      CFG_LOSS_REDUCTION: lossq_m     = 64'(val[8:0]);
      default: ;
    endcase
  endtask

  // Packet traffic: sends are remembered, and most acks, losses and marks
  // refer to one of them; the rest is noise with arbitrary sizes and stamps.
  task automatic queue_traffic(input int count);
    cc_event_t    e;
    unacked_pkt_t p;
    int           pick, sz, idx;
    for (int i = 0; i < count; i++) begin
      stamp_now = stamp_now + TIME_BITS'($urandom_range(1, 16));
      pick      = $urandom_range(0, 99);
      sz        = $urandom_range(0, 9);
      e.counted = ($urandom_range(0, 9) != 0);
      e.sent    = stamp_now - TIME_BITS'($urandom_range(0, 40));
      e.now     = ($urandom_range(0, 11) == 0) ? rand_stamp() : stamp_now;
      if (sz < 7) e.bytes = 16'($urandom_range(1, 1500));
      else if (sz == 7) e.bytes = 16'd0;
      else if (sz == 8) e.bytes = 16'hFFFF;
      else e.bytes = 16'($urandom_range(0, 65535));
      if (pick < 30) e.op = OP_SENT;
      else if (pick < 62) e.op = OP_ACKED;
      else if (pick < 70) e.op = OP_LOST;
      else if (pick < 76) e.op = OP_ECN;
      else if (pick < 78) e.op = OP_PERSIST;
      else if (pick < 95) e.op = OP_QUERY;
      else if (pick < 98) e.op = OP_RESET;
      else e.op = OP_UNUSED;
      if (e.op == OP_SENT && unacked.size() < 64) begin
        p.bytes = e.bytes;
        p.stamp = stamp_now;
        unacked.push_back(p);
      end else if (e.op == OP_ACKED || e.op == OP_LOST || e.op == OP_ECN) begin
        if (unacked.size() > 0 && $urandom_range(0, 4) != 0) begin
          idx     = $urandom_range(0, unacked.size() - 1);
          e.bytes = unacked[idx].bytes;
          e.sent  = unacked[idx].stamp;
          unacked.delete(idx);
        end else if ($urandom_range(0, 3) == 0) begin
          e.sent = rand_stamp();
        end
      end else if (e.op == OP_RESET) begin
        unacked.delete();
      end
      req_backlog.push_back(e);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock and cycle limit.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver: present the next request from the backlog, hold it until
  // the block takes it, and predict its response at the accepting edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_req.valid <= 1'b0;
    end else begin
      if (in_req.valid && in_req.ready) begin
        report_expect.push_back(predict_event(offer));
      end
      if (!in_req.valid || in_req.ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_req.valid <= 1'b0;
        end else if (req_backlog.size() > 0) begin
          offer = req_backlog.pop_front();
          in_req.valid            <= 1'b1;
          in_req.op               <= offer.op;
          in_req.byte_count       <= offer.bytes;
          in_req.counts_in_flight <= offer.counted;
          in_req.send_stamp       <= offer.sent;
          in_req.now_time         <= offer.now;
          tx_gap = pick_gap();
        end else begin
          in_req.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Long receiver stall: a few times in the run, hold ready low through a
  // LONG_HOLD countdown so the block fills up and stalls its input while the
  // driver keeps offering.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
    end else if (responses_seen >= hold_mark) begin
      rx_hold   <= LONG_HOLD;
      hold_mark <= hold_mark + 550;
    end
  end

  // ---------------------------------------------------------------------------
  // Response monitor and receiver backpressure.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    window_report_t want;
    if (!rst_n) begin
      out_rsp.ready <= 1'b0;
    end else begin
      if (out_rsp.valid && out_rsp.ready) begin
        if (report_expect.size() == 0) begin
          $error("response %0d arrived with no request outstanding", responses_seen);
          mismatches++;
        end else begin
          want = report_expect.pop_front();
          check_field("window", want.window, out_rsp.window);
          check_field("threshold", want.threshold, out_rsp.threshold);
          check_field("in_flight_bytes", want.flight, out_rsp.in_flight_bytes);
          check_field("phase", want.phase, out_rsp.phase);
          check_field("room", want.room, out_rsp.room);
          check_field("send_ok", want.send_ok, out_rsp.send_ok);
        end
        responses_seen++;
      end
      if (rx_hold > 0) begin
        out_rsp.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_rsp.ready <= 1'b0;
      end else begin
        out_rsp.ready <= 1'b1;
        rx_gap = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: directed requests at the default settings, then phases of
  // random traffic, each under its own settings. Drain between phases so
  // settings only change while the block is idle.
  // ---------------------------------------------------------------------------
  initial begin
    logic [15:0] ds;
    logic [15:0] iw;
    logic [15:0] mw;
    logic [15:0] lq;

    calm           = 1'b0;
    stamp_now      = '0;

    rst_n                   <= 1'b0;
    cfg_req.valid           <= 1'b0;
    cfg_req.index           <= CFG_DATAGRAM_SIZE;
    cfg_req.data            <= '0;

    // Model starts from the power-on settings.
    dgram_m     = 64'(DS_RESET);
    init_pkts_m = 64'(IWP_RESET);
    min_pkts_m  = 64'(MWP_RESET);
    lossq_m     = 64'(LOSSQ_RESET);
    restart_model();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Queries on an empty pipe: any-room form and a full-size ask.
    push_req(OP_QUERY, 16'd0, 1'b1, '0, '0);
    push_req(OP_QUERY, 16'hFFFF, 1'b1, '0, '0);
    push_req(OP_SENT, 16'd1200, 1'b1, '0, 48'd1);
    push_req(OP_SENT, 16'hFFFF, 1'b1, '0, 48'd2);
    push_req(OP_QUERY, 16'd12000, 1'b1, '0, 48'd3);
    // Slow-start growth, zero bytes, and an ack that was never counted.
    push_req(OP_ACKED, 16'd1200, 1'b1, 48'd1, 48'd4);
    push_req(OP_ACKED, 16'd0, 1'b0, 48'd2, 48'd5);
    push_req(OP_ACKED, 16'hFFFF, 1'b0, 48'd2, 48'd6);
    // Loss opens recovery; older mark, equal-time ack and underflow ack stay in it.
    push_req(OP_LOST, 16'hFFFF, 1'b1, 48'd3, 48'd100);
    push_req(OP_ECN, 16'd0, 1'b1, 48'd50, 48'd110);
    push_req(OP_ACKED, 16'd1200, 1'b1, 48'd100, 48'd120);
    push_req(OP_ACKED, 16'd2000, 1'b1, 48'd60, 48'd121);
    // Newer ack leaves recovery and grows in congestion avoidance.
    push_req(OP_ACKED, 16'd1200, 1'b1, 48'd101, 48'd130);
    push_req(OP_ACKED, 16'hFFFF, 1'b1, 48'd140, 48'd141);
    push_req(OP_ECN, 16'd0, 1'b1, 48'd150, 48'd160);
    // Recovery start at the top of the time range.
    push_req(OP_LOST, 16'd500, 1'b0, STAMP_MAX, STAMP_MAX);
    push_req(OP_ACKED, 16'd1200, 1'b1, STAMP_MAX, STAMP_MAX);
    push_req(OP_PERSIST, 16'd0, 1'b1, '0, '0);
    push_req(OP_UNUSED, 16'hFFFF, 1'b1, STAMP_MAX, STAMP_MAX);
    push_req(OP_QUERY, 16'd0, 1'b0, '0, '0);
    push_req(OP_RESET, 16'hFFFF, 1'b1, STAMP_MAX, STAMP_MAX);
    push_req(OP_ACKED, 16'd1200, 1'b1, '0, '0);
    wait_quiet();

    for (int k = 0; k < 9; k++) begin
      case (k)
        0: begin ds = 16'd1200;  iw = 16'd10;  mw = 16'd2;   lq = 16'd128; end
        1: begin ds = 16'hFFFF;  iw = 16'd255; mw = 16'd255; lq = 16'd256; end
        2: begin ds = 16'd1;     iw = 16'd1;   mw = 16'd1;   lq = 16'd0;   end
        3: begin ds = 16'd1460;  iw = 16'd4;   mw = 16'd2;   lq = 16'd179; end
        4: begin ds = 16'd9000;  iw = 16'd32;  mw = 16'd4;   lq = 16'd230; end
        5: begin
          ds = 16'($urandom_range(1, 65535));
          iw = 16'($urandom_range(1, 255));
          mw = 16'($urandom_range(1, 255));
          lq = 16'($urandom_range(0, 256));
        end
        // No floor and full reduction: a loss leaves a zero window.
        6: begin ds = 16'd1200;  iw = 16'd10;  mw = 16'd0;   lq = 16'd0;   end
        // Reduction factor near two: repeated marks drive the window to full scale.
        7: begin ds = 16'd500;   iw = 16'd255; mw = 16'd1;   lq = 16'd511; end
        default: begin
          ds = 16'($urandom_range(500, 1500));
          iw = 16'($urandom_range(1, 20));
          mw = 16'($urandom_range(1, 4));
          lq = 16'($urandom_range(100, 230));
        end
      endcase
      calm = (k % 3 == 1);
      write_setting(CFG_DATAGRAM_SIZE, ds);
      write_setting(CFG_INITIAL_WINDOW, iw);
      write_setting(CFG_MIN_WINDOW, mw);
      write_setting(CFG_LOSS_REDUCTION, lq);

      case ($urandom_range(0, 2))
        0: stamp_now = '0;
        1: stamp_now = rand_stamp();
        default: stamp_now = STAMP_MAX - 48'd255;
      endcase
      if (k == 6 || k == 7) stamp_now = 48'd1000;
      unacked.delete();
      // Reload the window so the new datagram size takes effect.
      push_req(OP_RESET, 16'd0, 1'b0, '0, stamp_now);

      if (k == 6) begin
        push_req(OP_ECN, 16'd0, 1'b1, 48'd1001, 48'd1002);
        push_req(OP_QUERY, 16'd0, 1'b1, '0, '0);
        // Growth divide with a zero window.
        push_req(OP_ACKED, 16'hFFFF, 1'b1, 48'd1003, 48'd1004);
        push_req(OP_PERSIST, 16'd0, 1'b1, '0, '0);
        push_req(OP_ACKED, 16'd0, 1'b1, 48'd1005, 48'd1006);
        push_req(OP_ACKED, 16'd0, 1'b1, 48'd1007, 48'd1008);
        stamp_now = 48'd1010;
      end
      if (k == 7) begin
        for (int j = 0; j < 20; j++) begin
          stamp_now = stamp_now + 48'd2;
          push_req(OP_ECN, 16'd0, 1'b1, stamp_now - 48'd1, stamp_now);
        end
        push_req(OP_ACKED, 16'hFFFF, 1'b1, stamp_now + 48'd1, stamp_now + 48'd2);
        push_req(OP_SENT, 16'hFFFF, 1'b1, '0, stamp_now + 48'd3);
        push_req(OP_QUERY, 16'hFFFF, 1'b1, '0, stamp_now + 48'd4);
        stamp_now = stamp_now + 48'd5;
      end

      queue_traffic($urandom_range(195, 225));
      wait_quiet();
    end

    // Give a stray late response time to show up.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
